// ===== rtl/wgsc_pkg.sv =====
// Shared constants, opcodes and controller/datapath handshake types.
package wgsc_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned WEIGHT_BITS_DEF  = 32;

  localparam int unsigned VCOUNT_W    = 7;
  localparam int unsigned VERTEX_W    = 6;
  localparam int unsigned IN_WEIGHT_W = 32;
  localparam int unsigned TOTAL_W     = 11;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = 7'd64;
  localparam logic [TOTAL_W-1:0]  EDGE_TOTAL_MAX = 11'd2047;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_WALK = 2'd2;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic exec;
    logic read_fwd;
    logic read_take;
    logic add_chk;
    logic add_wr2;
    logic walk_init;
    logic pop_issue;
    logic pop_take;
    logic scan;
    logic walk_end;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_add;
    logic is_read;
    logic is_walk;
    logic range_err;
    logic self_edge;
    logic n_zero;
    logic stack_empty;
    logic scan_done;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/wgsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wgsc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wgsc_ctrl.sv =====
// Controller state machine sequencing requests, the clearing pass and the walk.
module wgsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wgsc_pkg::status_t  st_i,
  output wgsc_pkg::cmd_t     cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_EXEC   = 10'b00_0000_0100,
    S_RDWAIT = 10'b00_0000_1000,
    S_ADDCHK = 10'b00_0001_0000,
    S_ADDWR2 = 10'b00_0010_0000,
    S_POP    = 10'b00_0100_0000,
    S_POPW   = 10'b00_1000_0000,
    S_SCAN   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (st_i.is_walk) begin
          if (st_i.n_zero) begin
            state_d = S_DONE;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d = S_POP;
          end
        end else if ((st_i.is_add || st_i.is_read) && !st_i.range_err && !st_i.self_edge) begin
          cmd_o.read_fwd = 1'b1;
          state_d = st_i.is_add ? S_ADDCHK : S_RDWAIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd_o.read_take = 1'b1;
        state_d = S_DONE;
      end
      S_ADDCHK: begin
        cmd_o.add_chk = 1'b1;
        state_d = S_ADDWR2;
      end
      S_ADDWR2: begin
        cmd_o.add_wr2 = 1'b1;
        state_d = S_DONE;
      end
      S_POP: begin
        if (st_i.stack_empty) begin
          cmd_o.walk_end = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.pop_issue = 1'b1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        cmd_o.pop_take = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_POP;
        end
      end
      S_DONE: begin
        if (!st_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/wgsc_datapath.sv =====
// Datapath: weight table, walk stack, visit marks, counters and result register.
module wgsc_datapath #(
  parameter int unsigned MaxVertices = wgsc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned WeightBits  = wgsc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wgsc_pkg::VCOUNT_W-1:0]        cfg_wdata_i,
  input  logic [1:0]                           in_opcode_i,
  input  logic [wgsc_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [wgsc_pkg::OUT_TDATA_W-1:0]     out_data_o,
  input  wgsc_pkg::cmd_t                       cmd_i,
  output wgsc_pkg::status_t                    st_o
);

  localparam int unsigned VB = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam int unsigned TblDepth = MaxVertices * MaxVertices;
  localparam int unsigned AW = $clog2(TblDepth);
  localparam logic [63:0] NoEdge64 = (64'd1 << WeightBits) - 64'd1;
  localparam logic [WeightBits-1:0] NoEdge = WeightBits'(NoEdge64);
  localparam logic [WeightBits-1:0] MaxWeight = WeightBits'(NoEdge64 - 64'd1);

  function automatic logic [AW-1:0] tbl_addr(input logic [VB-1:0] r, input logic [VB-1:0] c);
    return AW'(32'(r) * 32'(MaxVertices) + 32'(c));
  endfunction

  // Latched request.
  logic [1:0]                      op_q;
  logic [wgsc_pkg::VERTEX_W-1:0]   a_q, b_q;
  logic [WeightBits-1:0]           w_q;
  logic [wgsc_pkg::VCOUNT_W-1:0]   vc_q;
  logic [wgsc_pkg::TOTAL_W-1:0]    total_q;
  logic [AW-1:0]                   clr_q;

  // Result fields.
  logic [31:0] res_wt_q;
  logic        res_pres_q, res_conn_q, res_err_q;

  // Walk state.
  logic [MaxVertices-1:0] seen_q;
  logic [CW-1:0]          seen_tot_q, depth_q, u_q;
  logic [VB-1:0]          v_q, pu_q;
  logic                   pend_q;

  logic                               out_valid_q;
  logic [wgsc_pkg::OUT_TDATA_W-1:0]   out_data_q;

  logic [wgsc_pkg::IN_WEIGHT_W-1:0] in_w;
  logic [WeightBits-1:0] w_sat;
  logic [31:0]   n_full;
  logic [CW-1:0] n;
  logic [VB-1:0] a_v, b_v;
  logic          range_err;
  logic          issue, hit;

  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr, tbl_raddr;
  logic [WeightBits-1:0] tbl_wdata, tbl_rdata;
  logic [63:0]           rd_ext;

  logic          stk_we;
  logic [VB-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  assign in_w   = in_data_i[43:12];
  assign w_sat  = ({32'd0, in_w} >= NoEdge64) ? MaxWeight : WeightBits'({32'd0, in_w});
  assign n_full = (32'(vc_q) > 32'(MaxVertices)) ? 32'(MaxVertices) : 32'(vc_q);
  assign n      = CW'(n_full);
  assign a_v    = VB'(a_q);
  assign b_v    = VB'(b_q);
  assign range_err = (32'(a_q) >= n_full) || (32'(b_q) >= n_full);
  assign issue  = (u_q < n);
  assign hit    = pend_q && !seen_q[pu_q] && (tbl_rdata != NoEdge);
  assign rd_ext = 64'(tbl_rdata);

  assign st_o.clr_last    = (clr_q == AW'(TblDepth - 1));
  assign st_o.is_add      = (op_q == wgsc_pkg::OP_ADD);
  assign st_o.is_read     = (op_q == wgsc_pkg::OP_READ);
  assign st_o.is_walk     = (op_q == wgsc_pkg::OP_WALK);
  assign st_o.range_err   = range_err;
  assign st_o.self_edge   = (a_q == b_q);
  assign st_o.n_zero      = (n == '0);
  assign st_o.stack_empty = (depth_q == '0);
  assign st_o.scan_done   = !issue && !pend_q;
  assign st_o.out_busy    = out_valid_q && !out_ready_i;

  // Weight table ports.
  always_comb begin
    tbl_we    = cmd_i.clear_wr || cmd_i.add_chk || cmd_i.add_wr2;
    tbl_waddr = tbl_addr(b_v, a_v);
    tbl_wdata = w_q;
    if (cmd_i.clear_wr) begin
      tbl_waddr = clr_q;
      tbl_wdata = NoEdge;
    end else if (cmd_i.add_chk) begin
      tbl_waddr = tbl_addr(a_v, b_v);
    end
    tbl_raddr = cmd_i.scan ? tbl_addr(v_q, VB'(u_q)) : tbl_addr(a_v, b_v);
  end

  // Stack ports: the initial push of vertex 0 or a push of a newly found vertex.
  always_comb begin
    stk_we    = cmd_i.walk_init || (cmd_i.scan && hit);
    stk_waddr = cmd_i.walk_init ? '0 : VB'(depth_q);
    stk_wdata = cmd_i.walk_init ? '0 : pu_q;
    stk_raddr = VB'(depth_q - CW'(1));
  end

  wgsc_ram #(
    .Width (WeightBits),
    .Depth (TblDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  wgsc_ram #(
    .Width (VB),
    .Depth (MaxVertices)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q <= in_opcode_i;
      a_q  <= in_data_i[5:0];
      b_q  <= in_data_i[11:6];
      w_q  <= w_sat;
    end
    if (cmd_i.exec) begin
      res_err_q  <= range_err && !op_q[1];
      res_wt_q   <= ((op_q == wgsc_pkg::OP_READ) && (range_err || (a_q == b_q)))
                    ? NoEdge64[31:0] : 32'd0;
      res_pres_q <= 1'b0;
      res_conn_q <= (op_q == wgsc_pkg::OP_WALK) && (n == '0);
    end
    if (cmd_i.read_take) begin
      res_wt_q   <= rd_ext[31:0];
      res_pres_q <= (tbl_rdata != NoEdge);
    end
    if (cmd_i.walk_end) begin
      res_conn_q <= (seen_tot_q == n);
    end
    if (cmd_i.pop_take) begin
      v_q <= stk_rdata;
    end
    if (cmd_i.scan) begin
      pu_q <= VB'(u_q);
    end
    if (cmd_i.emit) begin
      out_data_q <= {2'b00, res_err_q, total_q, res_conn_q, res_pres_q, res_wt_q};
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= wgsc_pkg::VCOUNT_RESET;
      total_q     <= '0;
      clr_q       <= '0;
      seen_q      <= '0;
      seen_tot_q  <= '0;
      depth_q     <= '0;
      u_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.add_chk && (tbl_rdata == NoEdge) && (total_q < wgsc_pkg::EDGE_TOTAL_MAX)) begin
        total_q <= total_q + wgsc_pkg::TOTAL_W'(1);
      end
      if (cmd_i.walk_init) begin
        seen_q     <= MaxVertices'(1);
        seen_tot_q <= CW'(1);
        depth_q    <= CW'(1);
      end
      if (cmd_i.pop_issue) begin
        depth_q <= depth_q - CW'(1);
      end
      if (cmd_i.pop_take) begin
        u_q    <= '0;
        pend_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        pend_q <= issue;
        if (issue) begin
          u_q <= u_q + CW'(1);
        end
        if (hit) begin
          seen_q[pu_q] <= 1'b1;
          seen_tot_q   <= seen_tot_q + CW'(1);
          depth_q      <= depth_q + CW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/weighted_graph_store_connectivity_top.sv =====
// Top level of the undirected weighted graph store with connectivity check.
//
// Requests enter on the slave stream: s_axis_tuser carries the opcode (add or
// update an edge, read an edge, connectivity check) and s_axis_tdata carries
// the two endpoints and the weight. Every request gives exactly one result on
// the master stream, holding the read weight, the present and connected flags,
// the current edge count and a range error flag.
// An add passes from the exec state through the check and second-write states,
// a read through the read-wait state, and a request with a range error, a self
// edge or the unused opcode 3 goes from exec straight to the done state. A
// connectivity check pops each reached vertex and scans its table row one
// entry per cycle, as the weight table has a single read port; with zero
// configured vertices it goes from exec straight to done. One request is in
// flight at a time; s_axis_tready is high only while the block is idle.
// After reset the weight table is swept to the no-edge value, one entry per
// cycle, over all MaxVertices * MaxVertices entries (4096 by default); no
// request is accepted during that pass, while vertex_count writes are taken.
// The result sits in an output register; if the receiver stalls, the block
// still accepts the next request and holds its result until the register frees.
module weighted_graph_store_connectivity_top #(
  parameter int unsigned MaxVertices = wgsc_pkg::MAX_VERTICES_DEF,
  parameter int unsigned WeightBits  = wgsc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: vertex_count.
  input  logic                              cfg_we_i,
  input  logic [wgsc_pkg::VCOUNT_W-1:0]     cfg_wdata_i,
  // Request stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // from_vertex[5:0], to_vertex[11:6], edge_weight[43:12], zero fill [47:44]
  input  logic [wgsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_weight[31:0], edge_present[32], graph_connected[33],
  // edge_total_out[44:34], range_error[45], zero fill [47:46]
  output logic [wgsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  wgsc_pkg::cmd_t    cmd;
  wgsc_pkg::status_t st;

  // The controller sequences every request and the walk.
  wgsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // The datapath holds the table, the walk stack and the result register.
  wgsc_datapath #(
    .MaxVertices (MaxVertices),
    .WeightBits  (WeightBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_opcode_i (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

// ===== tb/tb_weighted_graph_store_connectivity_top.sv =====
// Self-checking testbench for the weighted graph store with connectivity check.
`timescale 1ns / 1ps

module tb_weighted_graph_store_connectivity_top;

  localparam logic [31:0] NO_EDGE = 32'hFFFF_FFFF;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // Fields of one result, in the order they are packed on m_axis_tdata.
  typedef struct packed {
    logic        range_error;
    logic [10:0] edge_total;
    logic        connected;
    logic        present;
    logic [31:0] weight;
  } graph_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [wgsc_pkg::VCOUNT_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [wgsc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [wgsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  weighted_graph_store_connectivity_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Shadow copy of the graph, kept in step with every accepted request.
  logic [31:0] shadow_weight [64][64];
  logic [10:0] shadow_edges;
  logic [6:0]  shadow_vcount;

  graph_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;

  // Idle percentages of both sides, and the long receiver hold-off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_active = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // The cycle counter bounds the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Works out the one result of a request and updates the shadow graph.
  function automatic graph_result_t predict_graph_op(logic [1:0] op, logic [5:0] a,
                                                     logic [5:0] b, logic [31:0] w);
    graph_result_t r;
    int n;
    int depth;
    int reached;
    int v;
    bit seen [64];
    int walk_stk [64];
    r = '0;
    n = (shadow_vcount > 64) ? 64 : shadow_vcount;
    if (op == wgsc_pkg::OP_ADD || op == wgsc_pkg::OP_READ) begin
      if (a >= n || b >= n) begin
        r.range_error = 1'b1;
        if (op == wgsc_pkg::OP_READ) r.weight = NO_EDGE;
      end else if (op == wgsc_pkg::OP_ADD) begin
        if (a != b) begin
          if (w == NO_EDGE) w = NO_EDGE - 1;
          if (shadow_weight[a][b] == NO_EDGE && shadow_edges < wgsc_pkg::EDGE_TOTAL_MAX)
            shadow_edges++;
          shadow_weight[a][b] = w;
          shadow_weight[b][a] = w;
        end
      end else begin
        r.weight = (a == b) ? NO_EDGE : shadow_weight[a][b];
        r.present = (r.weight != NO_EDGE);
      end
    end else if (op == wgsc_pkg::OP_WALK) begin
      if (n == 0) begin
        r.connected = 1'b1;
      end else begin
        foreach (seen[i]) seen[i] = 1'b0;
        seen[0] = 1'b1;
        reached = 1;
        depth = 0;
        walk_stk[depth] = 0;
        depth++;
        while (depth > 0) begin
          depth--;
          v = walk_stk[depth];
          for (int u = 0; u < n; u++) begin
            if (!seen[u] && shadow_weight[v][u] != NO_EDGE) begin
              seen[u] = 1'b1;
              reached++;
              if (depth < 64) begin
                walk_stk[depth] = u;
                depth++;
              end
            end
          end
        end
        r.connected = (reached == n);
      end
    end
    r.edge_total = shadow_edges;
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_active) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    graph_result_t got;
    graph_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[45:0];
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result %h", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got.weight !== want.weight) begin
          error_count++;
          $display("%0t: read_weight expected %h actual %h", $realtime,
                   want.weight, got.weight);
        end
        if (got.present !== want.present) begin
          error_count++;
          $display("%0t: edge_present expected %b actual %b", $realtime,
                   want.present, got.present);
        end
        if (got.connected !== want.connected) begin
          error_count++;
          $display("%0t: graph_connected expected %b actual %b", $realtime,
                   want.connected, got.connected);
        end
        if (got.edge_total !== want.edge_total) begin
          error_count++;
          $display("%0t: edge_total_out expected %0d actual %0d", $realtime,
                   want.edge_total, got.edge_total);
        end
        if (got.range_error !== want.range_error) begin
          error_count++;
          $display("%0t: range_error expected %b actual %b", $realtime,
                   want.range_error, got.range_error);
        end
      end
    end
  end

  // Sends one request and records its predicted result once accepted.
  // tvalid stays high after acceptance until an idle gap of the next request or a drain drops it.
  task automatic send_request(logic [1:0] op, logic [5:0] a, logic [5:0] b,
                              logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, w, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results = {pending_results, predict_graph_op(op, a, b, w)};
  endtask

  // Drops tvalid, waits for all results, then adds idle slack.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(logic [6:0] n);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_vcount = n;
  endtask

  // Extremes of every field, every opcode and the named corner cases.
  task automatic test_directed();
    send_request(wgsc_pkg::OP_WALK, 0, 0, 0);
    send_request(wgsc_pkg::OP_READ, 0, 63, 0);
    send_request(wgsc_pkg::OP_ADD, 0, 63, 32'h0);
    send_request(wgsc_pkg::OP_ADD, 63, 0, NO_EDGE);
    send_request(wgsc_pkg::OP_READ, 0, 63, 0);
    send_request(wgsc_pkg::OP_ADD, 5, 5, 32'h1234);
    send_request(wgsc_pkg::OP_READ, 5, 5, 0);
    send_request(wgsc_pkg::OP_ADD, 1, 2, 32'hFFFF_FFFE);
    send_request(wgsc_pkg::OP_READ, 2, 1, 0);
    send_request(wgsc_pkg::OP_ADD, 42, 21, 32'h5555_AAAA);
    send_request(wgsc_pkg::OP_READ, 21, 42, 0);
    send_request(OP_UNUSED, 63, 63, NO_EDGE);
    send_request(wgsc_pkg::OP_WALK, 63, 63, 0);
    set_vertex_count(7'd0);
    send_request(wgsc_pkg::OP_WALK, 0, 0, 0);
    send_request(wgsc_pkg::OP_ADD, 0, 1, 7);
    send_request(wgsc_pkg::OP_READ, 0, 0, 0);
    set_vertex_count(7'd127);
    send_request(wgsc_pkg::OP_READ, 63, 0, 0);
    set_vertex_count(7'd3);
    send_request(wgsc_pkg::OP_WALK, 0, 0, 0);
    send_request(wgsc_pkg::OP_ADD, 0, 2, 9);
    send_request(wgsc_pkg::OP_WALK, 0, 0, 0);
    send_request(wgsc_pkg::OP_READ, 0, 63, 0);
  endtask

  // Random requests with mostly in-range endpoints on a random graph.
  task automatic test_random(int count, int n);
    logic [1:0] op;
    logic [5:0] a;
    logic [5:0] b;
    logic [31:0] w;
    set_vertex_count(n[6:0]);
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < 8) ? wgsc_pkg::OP_WALK :
           ($urandom_range(99) < 55 ? wgsc_pkg::OP_ADD : wgsc_pkg::OP_READ);
      if ($urandom_range(99) < 3) op = OP_UNUSED;
      a = (n > 0 && $urandom_range(99) < 90) ? 6'($urandom_range(n - 1)) : 6'($urandom);
      b = (n > 0 && $urandom_range(99) < 90) ? 6'($urandom_range(n - 1)) : 6'($urandom);
      w = ($urandom_range(99) < 5) ? NO_EDGE : $urandom;
      send_request(op, a, b, w);
    end
  endtask

  // Receiver holds off long while requests keep coming; then a drain and a walk.
  task automatic test_backpressure();
    fork
      begin
        hold_active <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_active <= 1'b0;
      end
    join_none
    for (int i = 0; i < 6; i++) begin
      send_request(wgsc_pkg::OP_READ, 6'($urandom_range(7)), 6'($urandom_range(7)), 0);
    end
    drain_results();
    send_request(wgsc_pkg::OP_WALK, 0, 0, 0);
  endtask

  initial begin
    foreach (shadow_weight[i, j]) shadow_weight[i][j] = NO_EDGE;
    shadow_edges = '0;
    shadow_vcount = wgsc_pkg::VCOUNT_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    send_idle_pct = 16;
    recv_idle_pct = 68;
    test_random(280, 8);
    send_idle_pct = 68;
    recv_idle_pct = 16;
    test_random(280, 64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250, 20);
    test_backpressure();
    test_random(40, 2);
    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
